// File: design/smde_pkg.sv
// shared types, constants and the sine table builder for the modulated delay core
// no dependencies
package smde_pkg;

	// fixed audio settings
	localparam int SAMPLE_RATE  = 48000;
	localparam int SINE_ENTRIES = 1024;
	localparam int SAMPLE_BITS  = 24;
	localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
	localparam int DELAY_DEPTH_DEF = 2048;

	// samples per millisecond, the rate is a whole number of kHz
	localparam int SR_PER_MS = SAMPLE_RATE / 1000;

	// delay base in samples with 16 fraction bits, span in whole samples
	localparam int CHORUS_BASE   = SR_PER_MS * 5 * 65536;
	localparam int FLANGER_BASE  = SR_PER_MS * 1 * 65536;
	localparam int CHORUS_SPAN   = SR_PER_MS * 25;
	localparam int FLANGER_SPAN  = SR_PER_MS * 4;

	// configuration register reset values
	localparam logic [16:0] WET_RST    = 17'd0;
	localparam logic [16:0] DEPTH_RST  = 17'd32768;
	localparam logic [20:0] STEP_RST   = 21'd894785;
	localparam logic [16:0] UNITY      = 17'h10000;

	// polynomial coefficients for sin(pi/2 * x), Q30
	localparam longint unsigned SC1 = 64'd1686629713;
	localparam longint unsigned SC3 = 64'd693598669;
	localparam longint unsigned SC5 = 64'd85569278;
	localparam longint unsigned SC7 = 64'd5027003;
	localparam longint unsigned SC9 = 64'd172271;

	typedef enum logic [2:0] {
		REG_WET_MIX      = 3'd0,
		REG_MOD_DEPTH    = 3'd1,
		REG_PHASE_STEP   = 3'd2,
		REG_PHASE_OFFSET = 3'd3,
		REG_FB_GAIN      = 3'd4,
		REG_EFFECT_MODE  = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_WRITE,
		OP_SINE,
		OP_MDEPTH,
		OP_MSPAN,
		OP_ADDR,
		OP_RDA,
		OP_RDB,
		OP_MFRAC,
		OP_MGAIN,
		OP_MDRY,
		OP_MWET,
		OP_SUM,
		OP_FINISH
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SINE,
		ST_MDEPTH,
		ST_MSPAN,
		ST_ADDR,
		ST_RDA,
		ST_RDB,
		ST_MFRAC,
		ST_MGAIN,
		ST_MDRY,
		ST_MWET,
		ST_SUM,
		ST_FINISH
	} state_t;

	typedef struct packed {
		op_t  op;
		logic ch;
	} cmd_t;

	// sine table entry k, Q1.15, rounded half up
	function automatic logic signed [15:0] sine_entry(input int k);
		longint unsigned four, q, r, x, x2, p, m;
		four = longint'(k) * 4;
		q = four / SINE_ENTRIES;
		r = four % SINE_ENTRIES;
		x = (r << 30) / SINE_ENTRIES;
		if (q[0])
			x = (64'd1 << 30) - x;
		x2 = (x * x) >> 30;
		p = SC9;
		p = SC7 - ((p * x2) >> 30);
		p = SC5 - ((p * x2) >> 30);
		p = SC3 - ((p * x2) >> 30);
		p = SC1 - ((p * x2) >> 30);
		m = (((p * x) >> 30) + 64'd16384) >> 15;
		if (m > 64'd32767)
			m = 64'd32767;
		return (q >= 2) ? -$signed(m[15:0]) : $signed(m[15:0]);
	endfunction

	// saturate to a 24 bit sample
	function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
		if (v > 44'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -44'sd8388608)
			return 24'sh800000;
		else
			return v[23:0];
	endfunction

endpackage

// File: design/smde_ctrl.sv
// frame sequencer for the modulated delay core
// depends on smde_pkg
module smde_ctrl import smde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   ch_q;
	logic   out_valid_q;

	// state, channel and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WRITE)
				ch_q <= 1'b0;
			else if (state_q == ST_SUM)
				ch_q <= 1'b1;
			if (state_q == ST_FINISH && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd.ch   = ch_q;
		cmd.op   = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_WRITE;
				end
			end
			ST_WRITE:  begin cmd.op = OP_WRITE;  state_d = ST_SINE;   end
			ST_SINE:   begin cmd.op = OP_SINE;   state_d = ST_MDEPTH; end
			ST_MDEPTH: begin cmd.op = OP_MDEPTH; state_d = ST_MSPAN;  end
			ST_MSPAN:  begin cmd.op = OP_MSPAN;  state_d = ST_ADDR;   end
			ST_ADDR:   begin cmd.op = OP_ADDR;   state_d = ST_RDA;    end
			ST_RDA:    begin cmd.op = OP_RDA;    state_d = ST_RDB;    end
			ST_RDB:    begin cmd.op = OP_RDB;    state_d = ST_MFRAC;  end
			ST_MFRAC:  begin cmd.op = OP_MFRAC;  state_d = ST_MGAIN;  end
			ST_MGAIN:  begin cmd.op = OP_MGAIN;  state_d = ST_MDRY;   end
			ST_MDRY:   begin cmd.op = OP_MDRY;   state_d = ST_MWET;   end
			ST_MWET:   begin cmd.op = OP_MWET;   state_d = ST_SUM;    end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ch_q ? ST_FINISH : ST_SINE;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/smde_datapath.sv
// delay rings, sine table, shared multiplier and configuration registers
// depends on smde_pkg
module smde_datapath import smde_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [20:0]        cfg_data,
	input  logic signed [23:0] left_in,
	input  logic signed [23:0] right_in,
	output logic signed [23:0] left_out,
	output logic signed [23:0] right_out
);

	localparam int PW = $clog2(DELAY_DEPTH);
	localparam int QW = PW + 17;
	localparam logic [QW-1:0] RING_Q = QW'(DELAY_DEPTH) << 16;
	localparam logic [PW-1:0] LAST   = PW'(DELAY_DEPTH - 1);

	// configuration registers
	logic [16:0] wet_q, depth_q;
	logic [20:0] step_q;
	logic [15:0] offset_q, gain_q;
	logic        mode_q;

	// frame state
	logic [PW-1:0]      wp_q;
	logic               wrapped_q;
	logic [31:0]        phase_q;
	logic signed [23:0] fb_q [2];

	// working registers
	logic signed [23:0] in_q [2];
	logic signed [23:0] res_q [2];
	logic signed [15:0] sine_q;
	logic [PW+15:0]     pos_q;
	logic signed [23:0] lmem_q, rmem_q, a_q, del_q;
	logic               ok_q;
	logic signed [42:0] prod_q, acc_q;
	logic signed [23:0] out_l_q, out_r_q;

	logic signed [23:0] left_ring  [DELAY_DEPTH];
	logic signed [23:0] right_ring [DELAY_DEPTH];
	logic signed [15:0] sine_rom [SINE_ENTRIES];

	// sine table as constant logic
	for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
		assign sine_rom[k] = sine_entry(k);
	end

	// configuration writes, depth and mix clamp to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q    <= WET_RST;
			depth_q  <= DEPTH_RST;
			step_q   <= STEP_RST;
			offset_q <= '0;
			gain_q   <= '0;
			mode_q   <= 1'b0;
		end else if (cfg_write) begin
			priority case (cfg_index)
				REG_WET_MIX:      wet_q    <= (cfg_data[16:0] > UNITY) ? UNITY : cfg_data[16:0];
				REG_MOD_DEPTH:    depth_q  <= (cfg_data[16:0] > UNITY) ? UNITY : cfg_data[16:0];
				REG_PHASE_STEP:   step_q   <= cfg_data;
				REG_PHASE_OFFSET: offset_q <= cfg_data[15:0];
				REG_FB_GAIN:      gain_q   <= cfg_data[15:0];
				REG_EFFECT_MODE:  mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// lfo phase of the current channel and table index
	logic [31:0]           ph;
	logic [SINE_BITS-1:0]  sidx;
	assign ph   = cmd.ch ? phase_q + {offset_q, 16'h0} : phase_q;
	assign sidx = ph[31 -: SINE_BITS];

	// fractional read position behind the write pointer
	logic [15:0]    u;
	logic [QW-1:0]  d_v, pos_raw, pos_v;
	assign u       = prod_q[31:16] + 16'h8000;
	assign d_v     = prod_q[QW-1:0] + QW'(mode_q ? FLANGER_BASE : CHORUS_BASE);
	assign pos_raw = {1'b0, wp_q, 16'h0} + RING_Q - d_v;
	assign pos_v   = (pos_raw >= RING_Q) ? pos_raw - RING_Q : pos_raw;

	// tap addresses
	logic [PW-1:0] cur, nxt, rd_addr;
	assign cur     = pos_q[PW+15:16];
	assign nxt     = (cur == LAST) ? '0 : cur + 1'b1;
	assign rd_addr = (cmd.op == OP_RDA) ? cur : nxt;

	// entries not yet written read as zero
	logic signed [23:0] mem_v, del_v;
	assign mem_v = !ok_q ? 24'sd0 : (cmd.ch ? rmem_q : lmem_q);
	assign del_v = 24'(25'(a_q) + prod_q[40:16]);

	// shared multiplier operand selection
	logic signed [24:0] mul_a;
	logic signed [17:0] mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MDEPTH: begin mul_a = 25'(sine_q);   mul_b = {1'b0, depth_q};  end
			OP_MSPAN: begin
				mul_a = {9'b0, u};
				mul_b = 18'(mode_q ? FLANGER_SPAN : CHORUS_SPAN);
			end
			OP_MFRAC: begin mul_a = 25'(mem_v) - 25'(a_q); mul_b = {2'b0, pos_q[15:0]}; end
			OP_MGAIN: begin mul_a = 25'(del_v);    mul_b = {2'b0, gain_q};   end
			OP_MDRY:  begin mul_a = 25'(in_q[cmd.ch]); mul_b = {1'b0, 17'(UNITY - wet_q)}; end
			OP_MWET:  begin mul_a = 25'(del_q);    mul_b = {1'b0, wet_q};    end
			default: ;
		endcase
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			phase_q   <= '0;
			fb_q[0]   <= '0;
			fb_q[1]   <= '0;
		end else begin
			if (cmd.op == OP_WRITE) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
				if (wp_q == LAST)
					wrapped_q <= 1'b1;
			end
			if (cmd.op == OP_MDRY)
				fb_q[cmd.ch] <= prod_q[39:16];
			if (cmd.op == OP_FINISH)
				phase_q <= phase_q + 32'(step_q);
		end
	end

	// ring writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE) begin
			left_ring[wp_q]  <= sat24(44'(in_q[0]) + 44'(fb_q[0]));
			right_ring[wp_q] <= sat24(44'(in_q[1]) + 44'(fb_q[1]));
		end
		lmem_q <= left_ring[rd_addr];
		rmem_q <= right_ring[rd_addr];
		ok_q   <= wrapped_q || (rd_addr < wp_q);
	end

	// working payload registers
	always_ff @(posedge clk) begin
		prod_q <= 43'(mul_a * mul_b);
		unique case (cmd.op)
			OP_LOAD: begin
				in_q[0] <= left_in;
				in_q[1] <= right_in;
			end
			OP_SINE:  sine_q <= sine_rom[sidx];
			OP_ADDR:  pos_q  <= pos_v[PW+15:0];
			OP_RDB:   a_q    <= mem_v;
			OP_MGAIN: del_q  <= del_v;
			OP_MWET:  acc_q  <= prod_q;
			OP_SUM:   res_q[cmd.ch] <= sat24((44'(acc_q) + 44'(prod_q)) >>> 16);
			OP_FINISH: begin
				out_l_q <= res_q[0];
				out_r_q <= res_q[1];
			end
			default: ;
		endcase
	end

	assign left_out  = out_l_q;
	assign right_out = out_r_q;

endmodule

// File: design/stereo_modulated_delay_effect_core.sv
// stereo chorus / flanger core: sequencer and datapath
// depends on smde_pkg, smde_ctrl, smde_datapath
//
//  port group   direction  handshake             payload
//  input frame  in         in_valid / in_ready   left_in, right_in
//  result frame out        out_valid / out_ready left_out, right_out
//  config       in         cfg_write             cfg_index, cfg_data
//
// a frame: accept, ring write, then per channel sine, depth, span, address, two ring
// reads, fraction, gain, dry, wet and sum on the single shared multiplier and ring
// read port, then hand-over to the output register, which frees the sequencer while
// a result waits; the hand-over stalls only when a previous result is not taken
// reset needs no clearing pass: unwritten ring entries are tracked by a fill flag
module stereo_modulated_delay_effect_core import smde_pkg::*; #(
	parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] left_in,
	input  logic signed [23:0] right_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] left_out,
	output logic signed [23:0] right_out,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [20:0]        cfg_data
);

	cmd_t cmd;

	smde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	smde_datapath #(.DELAY_DEPTH(DELAY_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.left_in   (left_in),
		.right_in  (right_in),
		.left_out  (left_out),
		.right_out (right_out)
	);

	// one frame in flight: ready drops after a transfer
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a frame is in flight");

	// a new result is presented as the sequencer goes back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result presented without returning to idle");

	// the hand-over never coincides with accepting a frame
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !(cmd.op == OP_FINISH))
		else $error("hand-over while accepting a frame");

endmodule
